[rtl/hpe_pkg.sv]
`timescale 1ns / 1ps

package hpe_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_DEGREE = 6;
    localparam int NUM_COEFS  = MAX_DEGREE + 1;
    localparam int DEG_W      = 3;
    localparam int CFG_IDX_W  = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FIRST = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST  = CFG_IDX_W'(NUM_COEFS);

    typedef logic signed [DATA_W-1:0] coef_arr_t [NUM_COEFS];

    // commands from the controller to the datapath
    typedef struct packed {
        logic             load;
        logic             mul;
        logic             add;
        logic             out_load;
        logic [DEG_W-1:0] coef_sel;
    } hpe_cmd_t;

endpackage

[rtl/horner_polynomial_eval.sv]
`timescale 1ns / 1ps
// Horner evaluation on one shared 32x32 multiplier, each step a multiply
// and then a round/add/saturate. Output valid rises after the MUL/ADD states
// of every step and the DONE state; a new point is taken only in the idle state,
// once the previous result is in the output register, where it may still wait.
// rst_n clears control state and all configuration registers to zero.

module horner_polynomial_eval
    import hpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] point
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata,   // [31:0] poly_value
    output logic                 m_axis_tuser,   // [0] overflowed
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    logic [DEG_W-1:0]         degree_reg;
    coef_arr_t                coef_reg;
    hpe_cmd_t                 cmd;
    logic signed [DATA_W-1:0] poly_value;
    logic                     cfg_write;
    logic [CFG_IDX_W-1:0]     coef_idx;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign coef_idx  = cfg_index - CFG_COEF_FIRST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= '0;
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            // drop writes beyond the register list
            if (cfg_index == CFG_DEGREE)
            begin
                degree_reg <= cfg_data[DEG_W-1:0];
            end
            else if (cfg_index <= CFG_COEF_LAST)
            begin
                coef_reg[coef_idx[DEG_W-1:0]] <= $signed(cfg_data);
            end
        end
    end

    hpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .degree    (degree_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    hpe_datapath u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .point      ($signed(s_axis_tdata)),
        .coefs      (coef_reg),
        .poly_value (poly_value),
        .overflowed (m_axis_tuser)
    );

    assign m_axis_tdata = poly_value;

endmodule

[rtl/hpe_datapath.sv]
`timescale 1ns / 1ps

module hpe_datapath
    import hpe_pkg::*;
(
    input  logic                     clk,
    input  hpe_cmd_t                 cmd,
    input  logic signed [DATA_W-1:0] point,
    input  coef_arr_t                coefs,
    output logic signed [DATA_W-1:0] poly_value,
    output logic                     overflowed
);

    localparam int PROD_W = 2 * DATA_W;
    localparam int HI_W   = PROD_W - FRAC_BITS;
    localparam int SUM_W  = HI_W + 1;
    localparam int TOP_W  = SUM_W - DATA_W + 1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     sat_reg, sat_next;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_ovf_reg;

    logic signed [DATA_W-1:0] coef_val;
    logic signed [SUM_W-1:0]  hi_ext;
    logic signed [SUM_W-1:0]  coef_ext;
    logic signed [SUM_W-1:0]  rnd_bit;
    logic signed [SUM_W-1:0]  sum;
    logic [TOP_W-1:0]         sum_top;
    logic                     step_ovf;
    logic signed [DATA_W-1:0] step_val;

    assign coef_val  = coefs[cmd.coef_sel];
    assign prod_next = acc_reg * x_reg;

    // round half up: floor(p / 2^F) plus the first dropped bit, folded into one add
    assign hi_ext   = SUM_W'($signed(prod_reg[PROD_W-1:FRAC_BITS]));
    assign coef_ext = SUM_W'(coef_val);
    assign rnd_bit  = {{(SUM_W-1){1'b0}}, prod_reg[FRAC_BITS-1]};
    assign sum      = hi_ext + coef_ext + rnd_bit;

    assign sum_top  = sum[SUM_W-1:DATA_W-1];
    assign step_ovf = !((&sum_top) || !(|sum_top));
    assign step_val = step_ovf ? (sum[SUM_W-1] ? SAT_MIN : SAT_MAX) : sum[DATA_W-1:0];

    always_comb
    begin
        acc_next = acc_reg;
        sat_next = sat_reg;
        if (cmd.load)
        begin
            acc_next = coef_val;
            sat_next = 1'b0;
        end
        else if (cmd.add)
        begin
            acc_next = step_val;
            sat_next = sat_reg | step_ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sat_reg <= sat_next;
        if (cmd.load)
        begin
            x_reg <= point;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.out_load)
        begin
            out_value_reg <= acc_reg;
            out_ovf_reg   <= sat_reg;
        end
    end

    assign poly_value = out_value_reg;
    assign overflowed = out_ovf_reg;

endmodule

[rtl/hpe_ctrl.sv]
`timescale 1ns / 1ps

module hpe_ctrl
    import hpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DEG_W-1:0] degree,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output hpe_cmd_t         cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [DEG_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [DEG_W-1:0] deg_eff;
    logic             out_free;

    // codes above the top degree act as the top degree
    assign deg_eff  = (degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.coef_sel   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.coef_sel = deg_eff;
                if (in_valid)
                begin
                    // top coefficient enters directly: the first product is zero
                    cmd.load = 1'b1;
                    if (deg_eff == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = deg_eff - DEG_W'(1);
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add = 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg - DEG_W'(1);
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                // hold until the output register frees up
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[dv/horner_polynomial_eval_tb.sv]
`timescale 1ns / 1ps

module horner_polynomial_eval_tb;
    import hpe_pkg::*;

    localparam int   WATCHDOG_LIMIT = 5000;
    localparam int   TAIL_CYCLES    = 2 * MAX_DEGREE + 6;
    localparam int   NUM_PHASES     = 10;
    localparam int   PHASE_POINTS   = 183;
    localparam longint POS_LIMIT    = 64'sd2147483647;
    localparam longint NEG_LIMIT    = -64'sd2147483648;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_COEF_LAST + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic signed [DATA_W-1:0] point;
        logic signed [DATA_W-1:0] value;
        logic                     overflow;
    } poly_result_t;

    class horner_scoreboard;
        logic [DEG_W-1:0]         degree_reg;
        logic signed [DATA_W-1:0] coef_reg [NUM_COEFS];
        poly_result_t             pending_values [$];
        int unsigned              error_count;

        function new();
            degree_reg  = '0;
            error_count = 0;
            foreach (coef_reg[i])
                coef_reg[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            if (idx == CFG_DEGREE)
                degree_reg = data[DEG_W-1:0];
            else if (idx >= CFG_COEF_FIRST && idx <= CFG_COEF_LAST)
                coef_reg[idx - CFG_COEF_FIRST] = data;
        endfunction

        // Horner steps from the top coefficient down; only the sum saturates
        function void note_point(logic signed [DATA_W-1:0] x);
            poly_result_t res;
            int           top;
            longint       acc;
            longint       prod;
            longint       sum;
            top = (degree_reg > MAX_DEGREE) ? MAX_DEGREE : int'(degree_reg);
            acc = 0;
            res.point    = x;
            res.overflow = 1'b0;
            for (int i = top; i >= 0; i--)
            begin
                prod = (acc * longint'(x) + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
                sum  = prod + longint'(coef_reg[i]);
                if (sum > POS_LIMIT)
                begin
                    sum          = POS_LIMIT;
                    res.overflow = 1'b1;
                end
                else if (sum < NEG_LIMIT)
                begin
                    sum          = NEG_LIMIT;
                    res.overflow = 1'b1;
                end
                acc = sum;
            end
            res.value = acc[DATA_W-1:0];
            pending_values.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            error_count++;
        endtask

        task check_result(logic [DATA_W-1:0] value, logic ovf);
            poly_result_t want;
            if (pending_values.size() == 0)
            begin
                report_mismatch($sformatf("result %h with no point outstanding", value));
                return;
            end
            want = pending_values.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("x=%h value %h, want %h",
                                          want.point, value, want.value));
            if (ovf !== want.overflow)
                report_mismatch($sformatf("x=%h overflow %b, want %b",
                                          want.point, ovf, want.overflow));
        endtask

        function int pending();
            return pending_values.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DATA_W-1:0]    m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [DATA_W-1:0]    cfg_data      = '0;

    int                   send_idle_pct = 0;
    int                   stall_pct     = 0;
    int                   quiet_cycles  = 0;

    horner_scoreboard     sb = new();

    horner_polynomial_eval i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task set_idle_mode(idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct = 54;
                stall_pct     = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct = 0;
                stall_pct     = 54;
            end
            default:
            begin
                send_idle_pct = 18;
                stall_pct     = 18;
            end
        endcase
    endtask

    // Leaves cfg_valid high unless this is the last write of a burst.
    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data, bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task send_point(logic signed [DATA_W-1:0] x);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_point(x);
    endtask

    // Drop valid, let every outstanding result drain, then give the block time to settle.
    task wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_extreme();
        case ($urandom_range(0, 6))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_0001;
            5:       return 32'h0001_0000;
            default: return 32'hFFFF_0000;
        endcase
    endfunction

    // Mostly small magnitudes keep the evaluation out of saturation.
    function automatic logic [DATA_W-1:0] rand_q16(int small_pct, int full_pct, int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < small_pct)
            return DATA_W'(int'($urandom_range(0, 2 * span)) - span);
        else if (r < small_pct + full_pct)
            return $urandom;
        else
            return pick_extreme();
    endfunction

    task program_all(logic [DATA_W-1:0] deg_data, logic [DATA_W-1:0] c [NUM_COEFS]);
        write_reg(CFG_DEGREE, deg_data, 1'b0);
        for (int i = 0; i < NUM_COEFS; i++)
            write_reg(CFG_COEF_FIRST + CFG_IDX_W'(i), c[i], i == NUM_COEFS - 1);
    endtask

    initial
    begin
        logic [DATA_W-1:0] c [NUM_COEFS];
        logic [DATA_W-1:0] deg_data;

        set_idle_mode(IDLE_NONE);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration evaluates to zero everywhere
        send_point(32'h7FFF_FFFF);
        send_point(32'h8000_0000);
        wait_drained();

        // degree zero returns the constant term untouched
        write_reg(CFG_DEGREE, 32'h0, 1'b0);
        write_reg(CFG_COEF_FIRST, 32'h8000_0000, 1'b1);
        send_point(32'h1234_5678);
        wait_drained();

        // rounding ties go toward plus infinity
        write_reg(CFG_DEGREE, 32'h1, 1'b0);
        write_reg(CFG_COEF_FIRST, 32'h0, 1'b0);
        write_reg(CFG_COEF_FIRST + CFG_IDX_W'(1), 32'h1, 1'b1);
        send_point(32'h0000_8000);
        send_point(32'hFFFF_8000);
        wait_drained();

        // product past the range pulled back by the coefficient, then a real clamp
        write_reg(CFG_COEF_FIRST, 32'hFFFF_FFFF, 1'b0);
        write_reg(CFG_COEF_FIRST + CFG_IDX_W'(1), 32'h4000_0000, 1'b1);
        send_point(32'h0002_0000);
        send_point(32'hFFFE_0000);
        wait_drained();

        // full degree, largest coefficients
        for (int i = 0; i < NUM_COEFS; i++)
            c[i] = 32'h7FFF_FFFF;
        program_all(32'h6, c);
        send_point(32'h7FFF_FFFF);
        send_point(32'h8000_0000);
        send_point(32'h0000_0000);
        send_point(32'hFFFF_FFFF);
        send_point(32'h0001_0000);
        send_point(32'hFFFF_0000);
        wait_drained();

        // degree code seven saturates to the top degree
        for (int i = 0; i < NUM_COEFS; i++)
            c[i] = (i % 2) ? 32'h8000_0000 : 32'h0003_0000;
        program_all(32'hFFFF_FFFF, c);
        send_point(32'h0001_0000);
        send_point(32'h0000_8000);
        send_point(32'h0000_0001);
        wait_drained();

        // upper coefficients stay set but lie above the degree; stray indexes do nothing
        write_reg(CFG_DEGREE, 32'hFFFF_FFFA, 1'b0);
        write_reg(CFG_COEF_FIRST, 32'h0000_4000, 1'b0);
        write_reg(CFG_COEF_FIRST + CFG_IDX_W'(1), 32'hFFFE_8000, 1'b0);
        write_reg(CFG_COEF_FIRST + CFG_IDX_W'(2), 32'h0000_C000, 1'b0);
        write_reg(CFG_UNUSED_LO, 32'hDEAD_BEEF, 1'b0);
        write_reg(CFG_UNUSED_HI, 32'h5A5A_A5A5, 1'b1);
        send_point(32'h0001_8000);
        send_point(32'hFFFE_8000);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       deg_data = 32'h0;
                1:       deg_data = 32'h6;
                2:       deg_data = 32'h7;
                default: deg_data = {29'($urandom_range(0, 32'h1FFF_FFFF)), 3'(p)};
            endcase
            for (int i = 0; i < NUM_COEFS; i++)
                c[i] = rand_q16(70, 20, 32'h2_0000);
            program_all(deg_data, c);
            set_idle_mode(idle_mode_t'(p % 4));
            for (int n = 0; n < PHASE_POINTS; n++)
            begin
                // hold the sender once until the pipeline is empty
                if (p == 5 && n == PHASE_POINTS / 2)
                    wait_drained();
                send_point(rand_q16(60, 25, 32'h4_0000));
            end
            wait_drained();
        end

        if (sb.error_count == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
